>>> hw/rtl/swm_pkg.sv
// shared constants and types for the sliding window maximum block
`timescale 1ns / 1ps
package swm_pkg;

  localparam int SampleW   = 32;
  localparam int MaxWindow = 32;
  localparam int CfgW      = 6;
  localparam int CntW      = $clog2(MaxWindow + 1);
  localparam int IdxW      = $clog2(MaxWindow);

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic [CfgW-1:0]           cfg_t;
  typedef logic [CntW-1:0]           cnt_t;
  typedef logic [IdxW-1:0]           idx_t;

  typedef struct packed {
    logic emit;
    idx_t sel;
  } swm_ctrl_t;

endpackage

>>> hw/rtl/swm_if.sv
// valid/ready channel interfaces for samples, results and configuration
`timescale 1ns / 1ps
interface swm_in_if;
  logic             valid;
  logic             ready;
  swm_pkg::sample_t sample;
  logic             first_of_array;

  modport source (output valid, output sample, output first_of_array, input ready);
  modport sink   (input valid, input sample, input first_of_array, output ready);
endinterface

interface swm_out_if;
  logic             valid;
  logic             ready;
  swm_pkg::sample_t window_max;

  modport source (output valid, output window_max, input ready);
  modport sink   (input valid, input window_max, output ready);
endinterface

interface swm_cfg_if;
  logic          valid;
  logic          ready;
  swm_pkg::cfg_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/swm_cell.sv
// one window cell: running maximum of the newest samples up to its depth
`timescale 1ns / 1ps
module swm_cell (
  input  logic             clk_i,
  input  logic             en_i,
  input  swm_pkg::sample_t sample_i,
  input  swm_pkg::sample_t prev_i,
  output swm_pkg::sample_t nxt_o,
  output swm_pkg::sample_t max_o
);
  import swm_pkg::*;

  sample_t max_q;
  sample_t max_d;

  assign max_d = (prev_i > sample_i) ? prev_i : sample_i;
  assign nxt_o = max_d;
  assign max_o = max_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      max_q <= max_d;
    end
  end

endmodule

>>> hw/rtl/swm_ctrl.sv
// window size register, fill count and result decision
`timescale 1ns / 1ps
module swm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  swm_pkg::cfg_t      cfg_data_i,
  input  logic               accept_i,
  input  logic               first_i,
  output swm_pkg::swm_ctrl_t ctrl_o
);
  import swm_pkg::*;

  cfg_t ws_q;
  cnt_t fill_q;
  cnt_t fill_d;
  cnt_t fill_base;
  cnt_t fill_inc;
  cnt_t k;
  logic emit;

  always_comb begin
    if (ws_q == '0) begin
      k = CntW'(1);
    end else if (ws_q > CfgW'(MaxWindow)) begin
      k = CntW'(MaxWindow);
    end else begin
      k = CntW'(ws_q);
    end
    fill_base = first_i ? '0 : fill_q;
    fill_inc  = (fill_base < CntW'(MaxWindow)) ? fill_base + CntW'(1) : fill_base;
    emit      = (fill_inc >= k);
    fill_d    = emit ? k - CntW'(1) : fill_inc;
  end

  assign ctrl_o.emit = emit;
  assign ctrl_o.sel  = IdxW'(k - CntW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q   <= CfgW'(1);
      fill_q <= '0;
    end else begin
      if (cfg_we_i) begin
        ws_q <= cfg_data_i;
      end
      if (accept_i) begin
        fill_q <= fill_d;
      end
    end
  end

endmodule

>>> hw/rtl/sliding_window_maximum.sv
// sliding window maximum: top level with the cell chain and output register
// a result is registered and shown in the cycle after the sample that completes the window
// throughput: one sample per cycle unless stalled; all max cells update in one step
// each cell takes max(new sample, left neighbor), so the window size only picks a tap
// a full output register stalls input only while its result is not taken
// reset clears fill count, output valid and sets window size to 1; cells need no reset
`timescale 1ns / 1ps
module sliding_window_maximum (
  input  logic       clk_i,
  input  logic       rst_ni,
  swm_in_if.sink     in_i,
  swm_out_if.source  out_o,
  swm_cfg_if.sink    cfg_i
);
  import swm_pkg::*;

  sample_t   cell_nxt [MaxWindow];
  sample_t   cell_max [MaxWindow];
  swm_ctrl_t ctrl;
  logic      accept;
  logic      out_valid_q;
  sample_t   out_data_q;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign accept      = in_i.valid && in_i.ready;

  swm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_i.valid),
    .cfg_data_i (cfg_i.data),
    .accept_i   (accept),
    .first_i    (in_i.first_of_array),
    .ctrl_o     (ctrl)
  );

  for (genvar j = 0; j < MaxWindow; j++) begin : g_cell
    sample_t prev;
    if (j == 0) begin : g_head
      assign prev = in_i.sample;
    end else begin : g_body
      assign prev = cell_max[j-1];
    end
    swm_cell u_cell (
      .clk_i    (clk_i),
      .en_i     (accept),
      .sample_i (in_i.sample),
      .prev_i   (prev),
      .nxt_o    (cell_nxt[j]),
      .max_o    (cell_max[j])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= ctrl.emit;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && ctrl.emit) begin
      out_data_q <= cell_nxt[ctrl.sel];
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.window_max = out_data_q;

endmodule

>>> hw/rtl/swm_checker.sv
// port-level checks for the sliding window maximum block
`timescale 1ns / 1ps
module swm_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input swm_pkg::sample_t out_data,
  input logic             cfg_ready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_new_from_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !$past(out_valid) |-> $past(in_valid && in_ready))
    else $error("result appeared without an input transfer");

  a_ready_only_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while output can move");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready)
    else $error("configuration channel not ready");

endmodule

bind sliding_window_maximum swm_checker u_swm_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_data  (out_o.window_max),
  .cfg_ready (cfg_i.ready)
);
